// File: src/equirectangular_distance_core_defines.svh
// assertion helpers used by the core rtl file
`ifndef EQUIRECTANGULAR_DISTANCE_CORE_DEFINES_SVH
`define EQUIRECTANGULAR_DISTANCE_CORE_DEFINES_SVH

// same-cycle implication, off while reset is asserted
`define EDC_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off while reset is asserted
`define EDC_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/edc_pkg.sv
`default_nettype none

package edc_pkg;

    localparam int ANGLE_FRAC_BITS = 20;

    localparam logic [22:0] RADIUS_RESET = 23'd6371000;
    localparam logic [25:0] DIST_MAX     = 26'd45000000;

    // round(pi/180 * 2^32)
    localparam logic [26:0] PIK = 27'd74961321;

    // angles of the latitude sum, in units of 2^-(F+1) degrees
    localparam logic [28:0] HALF_TURN    = 29'(64'd180 << (ANGLE_FRAC_BITS + 1));
    localparam logic [28:0] QUARTER_TURN = 29'(64'd90 << (ANGLE_FRAC_BITS + 1));
    localparam logic [28:0] EIGHTH_TURN  = 29'(64'd45 << (ANGLE_FRAC_BITS + 1));

    localparam int          TORAD_SHIFT = ANGLE_FRAC_BITS + 3;
    localparam logic [54:0] TORAD_RND   = 55'(64'd1 << (ANGLE_FRAC_BITS + 2));
    localparam int          ANG_SHIFT   = ANGLE_FRAC_BITS + 2;
    localparam logic [59:0] ANG_RND     = 60'(64'd1 << (ANGLE_FRAC_BITS + 1));

    localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

    localparam int N_TERMS = 5;

    // k*(k+1) divisors of the taylor terms
    localparam logic [6:0] COS_DIV [N_TERMS] = '{7'd2, 7'd12, 7'd30, 7'd56, 7'd90};
    localparam logic [6:0] SIN_DIV [N_TERMS] = '{7'd6, 7'd20, 7'd42, 7'd72, 7'd110};

    // floor(2^32 / divisor), quotient estimate is low by at most one
    localparam logic [31:0] COS_RECIP [N_TERMS] = '{
        32'(64'h1_0000_0000 / 64'd2),
        32'(64'h1_0000_0000 / 64'd12),
        32'(64'h1_0000_0000 / 64'd30),
        32'(64'h1_0000_0000 / 64'd56),
        32'(64'h1_0000_0000 / 64'd90)
    };
    localparam logic [31:0] SIN_RECIP [N_TERMS] = '{
        32'(64'h1_0000_0000 / 64'd6),
        32'(64'h1_0000_0000 / 64'd20),
        32'(64'h1_0000_0000 / 64'd42),
        32'(64'h1_0000_0000 / 64'd72),
        32'(64'h1_0000_0000 / 64'd110)
    };

endpackage

`default_nettype wire

// File: src/equirectangular_distance_core.sv
`default_nettype none
`include "equirectangular_distance_core_defines.svh"

// Equirectangular distance core. Each input transaction carries two points (latitude and
// longitude in signed degrees with 20 fractional bits); each produces exactly one output
// transaction with the distance in whole metres, rounded to nearest and saturated at
// 45000000. The longitude difference is used as is, not wrapped at the antimeridian.
// The core takes one transaction per clock unless a stalled output holds it. The entry
// stage loads at the accepting edge and 67 more stages follow, among them 32 square root
// stages (one bit each) and five taylor terms of the cosine (four stages each: multiply,
// round, reciprocal multiply, correct), then the output register. A stalled output only
// holds the pipeline once the last stage is also full, so bubbles are squeezed out. No
// clearing pass after reset. The user must write the radius register (reset 6371000)
// via cfg_wen/cfg_wdata only while no transaction is in flight; the core does not check.
module equirectangular_distance_core
    import edc_pkg::*;
(
    input  wire                aclk,
    input  wire                aresetn,

    input  wire                cfg_wen,
    input  wire         [22:0] cfg_wdata,

    input  wire                s_valid,
    output logic               s_ready,
    input  wire  signed [27:0] s_lat_a,
    input  wire  signed [28:0] s_lon_a,
    input  wire  signed [27:0] s_lat_b,
    input  wire  signed [28:0] s_lon_b,

    output logic               m_valid,
    input  wire                m_ready,
    output logic        [25:0] m_distance_m
);

    // stage k of the pipeline carries its valid bit in v_reg[k-1]
    localparam int LAT     = 68;
    localparam int C_STAGE = 28;
    localparam int NTS     = 4 * N_TERMS + 1;

    logic [LAT-1:0] v_reg;
    logic           en;
    logic           m_valid_reg;
    logic [25:0]    m_distance_reg;
    logic [22:0]    radius_reg;

    // hold only when the result register is full, not taken, and another result waits
    assign en      = !(m_valid_reg && !m_ready && v_reg[LAT-1]);
    assign s_ready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[LAT-2:0], s_valid};
        end
    end

    // radius register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg <= RADIUS_RESET;
        end else if (cfg_wen) begin
            radius_reg <= cfg_wdata;
        end
    end

    // ---------------------------------------------------------------
    // stage 1: latitude sum magnitude and coordinate differences
    // ---------------------------------------------------------------
    logic signed [28:0] lat_sum;
    logic signed [29:0] lon_d;
    logic signed [28:0] lat_d;
    logic        [28:0] a_reg;
    logic        [28:0] dlon_dly_reg [C_STAGE];
    logic        [27:0] dlat_dly_reg [C_STAGE];

    assign lat_sum = {s_lat_a[27], s_lat_a} + {s_lat_b[27], s_lat_b};
    assign lon_d   = {s_lon_b[28], s_lon_b} - {s_lon_a[28], s_lon_a};
    assign lat_d   = {s_lat_b[27], s_lat_b} - {s_lat_a[27], s_lat_a};

    always_ff @(posedge aclk) begin
        if (en) begin
            a_reg           <= lat_sum[28] ? 29'(-lat_sum) : 29'(lat_sum);
            dlon_dly_reg[0] <= lon_d[29] ? 29'(-lon_d) : 29'(lon_d);
            dlat_dly_reg[0] <= lat_d[28] ? 28'(-lat_d) : 28'(lat_d);
            for (int k = 1; k < C_STAGE; k++) begin
                dlon_dly_reg[k] <= dlon_dly_reg[k-1];
                dlat_dly_reg[k] <= dlat_dly_reg[k-1];
            end
        end
    end

    // ---------------------------------------------------------------
    // stages 2-7: fold to the first octant, angle to radians, x squared
    // the latitude sum never reaches a half turn, so no modulo is needed
    // ---------------------------------------------------------------
    logic [28:0] r_reg;
    logic [26:0] t_reg;
    logic        sin3_reg, sin4_reg, sin5_reg, sin6_reg;
    logic [53:0] tp_reg;
    logic [29:0] x5_reg, x6_reg;
    logic [59:0] xx_reg;

    logic [29:0]        ts_x2_reg  [NTS];
    logic [NTS-1:0]     ts_sin_reg;
    logic signed [32:0] ts_sum_reg [NTS];
    logic [30:0]        term_reg   [N_TERMS+1];

    always_ff @(posedge aclk) begin
        if (en) begin
            r_reg    <= (a_reg > QUARTER_TURN) ? HALF_TURN - a_reg : a_reg;
            sin3_reg <= r_reg > EIGHTH_TURN;
            t_reg    <= (r_reg > EIGHTH_TURN) ? 27'(QUARTER_TURN - r_reg) : 27'(r_reg);
            tp_reg   <= 54'(t_reg) * 54'(PIK);
            sin4_reg <= sin3_reg;
            x5_reg   <= 30'((55'(tp_reg) + TORAD_RND) >> TORAD_SHIFT);
            sin5_reg <= sin4_reg;
            xx_reg   <= 60'(x5_reg) * 60'(x5_reg);
            x6_reg   <= x5_reg;
            sin6_reg <= sin5_reg;
            // stage 7: x^2 in q30 and the starting term (x for sine, one for cosine)
            ts_x2_reg[0]  <= 30'((61'(xx_reg) + 61'(1) * 61'h2000_0000) >> 30);
            ts_sin_reg[0] <= sin6_reg;
            term_reg[0]   <= sin6_reg ? {1'b0, x6_reg} : ONE_Q30;
            ts_sum_reg[0] <= sin6_reg ? 33'(x6_reg) : 33'(ONE_Q30);
        end
    end

    // ---------------------------------------------------------------
    // stages 8-27: five taylor terms, four stages each
    // side band (x^2, sine flag, running sum) rides along in ts_*
    // ---------------------------------------------------------------
    genvar gj, gn;
    generate
        for (gj = 0; gj < NTS - 1; gj++) begin : g_side
            always_ff @(posedge aclk) begin
                if (en) begin
                    ts_x2_reg[gj+1]  <= ts_x2_reg[gj];
                    ts_sin_reg[gj+1] <= ts_sin_reg[gj];
                    if ((gj % 4 == 0) && (gj > 0)) begin
                        if ((gj / 4) % 2 == 1) begin
                            ts_sum_reg[gj+1] <= ts_sum_reg[gj] - 33'(term_reg[gj/4]);
                        end else begin
                            ts_sum_reg[gj+1] <= ts_sum_reg[gj] + 33'(term_reg[gj/4]);
                        end
                    end else begin
                        ts_sum_reg[gj+1] <= ts_sum_reg[gj];
                    end
                end
            end
        end

        for (gn = 0; gn < N_TERMS; gn++) begin : g_term
            logic [60:0] prod_reg;
            logic [30:0] p_reg;
            logic [30:0] pc_reg;
            logic [62:0] qe_reg;
            logic [31:0] recip;
            logic [6:0]  div;
            logic [30:0] q0;
            logic [37:0] rem;

            assign recip = ts_sin_reg[4*gn+2] ? SIN_RECIP[gn] : COS_RECIP[gn];
            assign div   = ts_sin_reg[4*gn+3] ? SIN_DIV[gn] : COS_DIV[gn];
            assign q0    = qe_reg[62:32];
            assign rem   = 38'(pc_reg) - 38'(q0) * 38'(div);

            always_ff @(posedge aclk) begin
                if (en) begin
                    prod_reg        <= 61'(term_reg[gn]) * 61'(ts_x2_reg[4*gn]);
                    p_reg           <= 31'((prod_reg + 61'h2000_0000) >> 30);
                    qe_reg          <= 63'(p_reg) * 63'(recip);
                    pc_reg          <= p_reg;
                    term_reg[gn+1]  <= q0 + 31'(rem >= 38'(div));
                end
            end
        end
    endgenerate

    // ---------------------------------------------------------------
    // stage 28: last term, clamp the cosine to [0, 1.0]
    // ---------------------------------------------------------------
    logic signed [32:0] sum_fin;
    logic        [30:0] c_reg;

    assign sum_fin = ts_sum_reg[NTS-1] - 33'(term_reg[N_TERMS]);

    always_ff @(posedge aclk) begin
        if (en) begin
            if (sum_fin < 0) begin
                c_reg <= '0;
            end else if (sum_fin > 33'(ONE_Q30)) begin
                c_reg <= ONE_Q30;
            end else begin
                c_reg <= 31'(sum_fin);
            end
        end
    end

    // ---------------------------------------------------------------
    // stages 29-32: scaled longitude, squares and their sum
    // ---------------------------------------------------------------
    logic [59:0] xp_reg;
    logic [59:0] ysq29_reg, ysq30_reg, ysq31_reg;
    logic [29:0] y_val;
    logic [31:0] xr_reg;
    logic [63:0] xsq_reg;

    assign y_val = {dlat_dly_reg[C_STAGE-1], 2'b00};

    logic [62:0] sq_rem_reg  [33];
    logic [31:0] sq_root_reg [33];

    always_ff @(posedge aclk) begin
        if (en) begin
            xp_reg         <= 60'(dlon_dly_reg[C_STAGE-1]) * 60'(c_reg);
            ysq29_reg      <= 60'(y_val) * 60'(y_val);
            xr_reg         <= 32'((61'(xp_reg) + 61'h800_0000) >> 28);
            ysq30_reg      <= ysq29_reg;
            xsq_reg        <= 64'(xr_reg) * 64'(xr_reg);
            ysq31_reg      <= ysq30_reg;
            sq_rem_reg[0]  <= 63'(xsq_reg + 64'(ysq31_reg));
            sq_root_reg[0] <= '0;
        end
    end

    // ---------------------------------------------------------------
    // stages 33-64: digit-by-digit square root, one root bit per stage
    // ---------------------------------------------------------------
    genvar gi;
    generate
        for (gi = 0; gi < 32; gi++) begin : g_sqrt
            localparam int B = 31 - gi;
            logic [65:0] trial;

            assign trial = ({34'd0, sq_root_reg[gi]} << (B + 1)) + (66'd1 << (2 * B));

            always_ff @(posedge aclk) begin
                if (en) begin
                    if (66'(sq_rem_reg[gi]) >= trial) begin
                        sq_rem_reg[gi+1]  <= sq_rem_reg[gi] - 63'(trial);
                        sq_root_reg[gi+1] <= sq_root_reg[gi] | (32'd1 << B);
                    end else begin
                        sq_rem_reg[gi+1]  <= sq_rem_reg[gi];
                        sq_root_reg[gi+1] <= sq_root_reg[gi];
                    end
                end
            end
        end
    endgenerate

    // ---------------------------------------------------------------
    // stages 65-68: to radians q32, times radius, round and saturate
    // ---------------------------------------------------------------
    logic [58:0] sk_reg;
    logic [36:0] ang_reg;
    logic [27:0] hi_reg;
    logic [54:0] lo_reg;
    logic [28:0] metres;
    logic [25:0] dist_reg;

    assign metres = 29'(hi_reg) + 29'((56'(lo_reg) + 56'h8000_0000) >> 32);

    always_ff @(posedge aclk) begin
        if (en) begin
            sk_reg   <= 59'(sq_root_reg[32]) * 59'(PIK);
            ang_reg  <= 37'((60'(sk_reg) + ANG_RND) >> ANG_SHIFT);
            hi_reg   <= 28'(radius_reg) * 28'(ang_reg[36:32]);
            lo_reg   <= 55'(radius_reg) * 55'(ang_reg[31:0]);
            dist_reg <= (metres > 29'(DIST_MAX)) ? DIST_MAX : 26'(metres);
        end
    end

    // output register, loads whenever it is empty or being taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (!m_valid_reg || m_ready) begin
            m_valid_reg <= v_reg[LAT-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!m_valid_reg || m_ready) begin
            m_distance_reg <= dist_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_distance_m = m_distance_reg;

    `EDC_ASSERT_IMP(a_dist_sat, aclk, aresetn, m_valid_reg, m_distance_reg <= DIST_MAX, "distance above saturation")
    `EDC_ASSERT_IMP(a_cos_range, aclk, aresetn, v_reg[C_STAGE-1], c_reg <= ONE_Q30, "cosine out of range")
    `EDC_ASSERT_NXT(a_enter, aclk, aresetn, s_valid && s_ready, v_reg[0], "accepted transaction lost at entry")
    `EDC_ASSERT_NXT(a_hold, aclk, aresetn, !en, $stable(v_reg), "pipeline moved while held")
    `EDC_ASSERT_IMP(a_full_stall, aclk, aresetn, m_valid_reg && !m_ready && v_reg[LAT-1], !s_ready, "input taken while full")

endmodule

`default_nettype wire

// File: dv/equirectangular_distance_core_tb.sv
`timescale 1ns / 100ps

module equirectangular_distance_core_tb;
    import edc_pkg::*;

    typedef longint unsigned u64;

    localparam int    LATENCY     = 69;
    localparam int    SETTLE      = LATENCY + 10;
    localparam int    N_RANDOM    = 1700;
    localparam int    QUIET_TAIL  = 200;
    localparam longint CYCLE_LIMIT = 400000;

    // one degree in the input scale
    localparam int DEG     = 1 << ANGLE_FRAC_BITS;
    localparam int LAT_MAX = 90 * DEG;
    localparam int LON_MAX = 180 * DEG;

    localparam u64 PIK_K = 64'(PIK);

    // a queued entry is either a pair of points or a fence that waits for the pipe to drain
    typedef struct {
        bit                 fence;
        bit                 wr_radius;
        logic        [22:0] radius;
        logic signed [27:0] lat_a;
        logic signed [28:0] lon_a;
        logic signed [27:0] lat_b;
        logic signed [28:0] lon_b;
    } pending_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               cfg_wen = 1'b0;
    logic        [22:0] cfg_wdata = '0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic signed [27:0] s_lat_a = '0;
    logic signed [28:0] s_lon_a = '0;
    logic signed [27:0] s_lat_b = '0;
    logic signed [28:0] s_lon_b = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic        [25:0] m_distance_m;

    pending_t    pending_q[$];
    logic [25:0] distance_q[$];

    logic [22:0] radius_now = RADIUS_RESET;
    int          n_sent = 0;
    int          n_checked = 0;
    int          n_errors = 0;
    int          n_saturated = 0;
    int          n_radius = 0;
    int          n_total = 0;
    longint      cycles = 0;

    equirectangular_distance_core dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wen      (cfg_wen),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_lat_a      (s_lat_a),
        .s_lon_a      (s_lon_a),
        .s_lat_b      (s_lat_b),
        .s_lon_b      (s_lon_b),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_distance_m (m_distance_m)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // ---------------------------------------------------------------------------------------
    // distance predictor
    // ---------------------------------------------------------------------------------------

    // degrees (units of 2^-(F+1)) to radians q30
    function automatic u64 angle_to_rad(u64 t);
        return (t * PIK_K + (64'd1 << (ANGLE_FRAC_BITS + 2))) >> (ANGLE_FRAC_BITS + 3);
    endfunction

    // five taylor terms after the first, truncated division per term
    function automatic longint taylor_q30(u64 x, u64 first, u64 k_first);
        u64     x2;
        u64     term;
        u64     k;
        longint acc;
        x2 = (x * x + (64'd1 << 29)) >> 30;
        term = first;
        acc = longint'(first);
        k = k_first;
        for (int n = 1; n <= 5; n++) begin
            term = ((term * x2 + (64'd1 << 29)) >> 30) / (k * (k + 1));
            if (n % 2 == 1) acc -= longint'(term);
            else acc += longint'(term);
            k += 2;
        end
        return acc;
    endfunction

    // |cos| of the mean latitude, folded into the first quadrant
    function automatic u64 mean_lat_cos(u64 lat_sum);
        u64     half_t;
        u64     quarter_t;
        u64     eighth_t;
        u64     r;
        longint c;
        half_t    = 64'd180 << (ANGLE_FRAC_BITS + 1);
        quarter_t = 64'd90 << (ANGLE_FRAC_BITS + 1);
        eighth_t  = 64'd45 << (ANGLE_FRAC_BITS + 1);
        r = lat_sum % half_t;
        if (r > quarter_t) r = half_t - r;
        if (r <= eighth_t) begin
            c = taylor_q30(angle_to_rad(r), 64'd1 << 30, 1);
        end else begin
            c = taylor_q30(angle_to_rad(quarter_t - r), angle_to_rad(quarter_t - r), 2);
        end
        if (c < 0) c = 0;
        if (c > longint'(64'd1 << 30)) c = longint'(64'd1 << 30);
        return u64'(c);
    endfunction

    function automatic u64 floor_sqrt(u64 v);
        u64 res;
        u64 bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic logic [25:0] predict_distance(pending_t p, logic [22:0] radius);
        longint la;
        longint lb;
        longint lsum;
        longint dlon_s;
        longint dlat_s;
        u64     c;
        u64     xs;
        u64     ys;
        u64     s;
        u64     t;
        u64     r;
        u64     metres;
        la = longint'(p.lat_a);
        lb = longint'(p.lat_b);
        lsum = la + lb;
        c = mean_lat_cos(u64'(lsum < 0 ? -lsum : lsum));
        dlon_s = longint'(p.lon_b) - longint'(p.lon_a);
        dlat_s = lb - la;
        if (dlon_s < 0) dlon_s = -dlon_s;
        if (dlat_s < 0) dlat_s = -dlat_s;
        xs = (u64'(dlon_s) * c + (64'd1 << 27)) >> 28;
        ys = u64'(dlat_s) << 2;
        s = floor_sqrt(xs * xs + ys * ys);
        t = (s * PIK_K + (64'd1 << (ANGLE_FRAC_BITS + 1))) >> (ANGLE_FRAC_BITS + 2);
        r = u64'(radius);
        metres = r * (t >> 32) + ((r * (t & 64'hFFFF_FFFF) + (64'd1 << 31)) >> 32);
        if (metres > u64'(DIST_MAX)) metres = u64'(DIST_MAX);
        return metres[25:0];
    endfunction

    // ---------------------------------------------------------------------------------------
    // stimulus queue
    // ---------------------------------------------------------------------------------------

    function automatic void push_pair(int la, int oa, int lb, int ob);
        pending_t p;
        p = '{default: '0};
        p.lat_a = la[27:0];
        p.lon_a = oa[28:0];
        p.lat_b = lb[27:0];
        p.lon_b = ob[28:0];
        pending_q.insert(pending_q.size(), p);
        n_total++;
    endfunction

    // drain the pipe, optionally followed by a radius write
    function automatic void push_fence(bit wr, logic [22:0] radius);
        pending_t p;
        p = '{default: '0};
        p.fence = 1'b1;
        p.wr_radius = wr;
        p.radius = radius;
        pending_q.insert(pending_q.size(), p);
    endfunction

    function automatic int rand_span(int lim);
        return int'($urandom_range(0, 2 * lim)) - lim;
    endfunction

    // mostly sensible geography, some short hops, some raw full-width noise
    function automatic void push_random_pair();
        int sel;
        int la;
        int oa;
        sel = $urandom_range(0, 9);
        if (sel < 5) begin
            push_pair(rand_span(LAT_MAX), rand_span(LON_MAX),
                      rand_span(LAT_MAX), rand_span(LON_MAX));
        end else if (sel < 8) begin
            la = rand_span(LAT_MAX);
            oa = rand_span(LON_MAX);
            push_pair(la, oa, la + rand_span(1 << $urandom_range(0, 20)),
                      oa + rand_span(1 << $urandom_range(0, 20)));
        end else begin
            push_pair(int'($urandom()), int'($urandom()), int'($urandom()), int'($urandom()));
        end
    endfunction

    initial begin
        logic [22:0] radii [6];
        int          per_phase;
        radii = '{RADIUS_RESET, 23'd1, 23'd8000000, 23'd0, 23'h7F_FFFF,
                  23'($urandom_range(1, 8000000))};
        per_phase = N_RANDOM / 6;

        push_fence(1'b1, radii[0]);
        // directed corners
        push_pair(0, 0, 0, 0);
        push_pair(0, 0, 0, 1);
        push_pair(1, 0, 0, 0);
        push_pair(LAT_MAX, LON_MAX, -LAT_MAX, -LON_MAX);
        push_pair(-LAT_MAX, -LON_MAX, LAT_MAX, LON_MAX);
        push_pair(0, LON_MAX, 0, -LON_MAX);
        push_pair(LAT_MAX, 0, LAT_MAX, LON_MAX);
        push_pair(-LAT_MAX, 0, -LAT_MAX, -LON_MAX);
        // antimeridian crossing, taken the long way round
        push_pair(10 * DEG, 179 * DEG, 10 * DEG, -179 * DEG);
        // mean latitude on the cosine/sine switch and just either side
        push_pair(45 * DEG, 0, 45 * DEG, 10 * DEG);
        push_pair(45 * DEG, 0, 45 * DEG + 1, 10 * DEG);
        push_pair(45 * DEG - 1, 0, 45 * DEG, 10 * DEG);
        push_pair(-45 * DEG, 3 * DEG, -45 * DEG, -3 * DEG);
        // coordinates beyond range, periodic cosine and saturation
        push_pair(-(1 << 27), -(1 << 28), (1 << 27) - 1, (1 << 28) - 1);
        push_pair((1 << 27) - 1, (1 << 28) - 1, -(1 << 27), -(1 << 28));
        push_pair((1 << 27) - 1, 0, (1 << 27) - 1, 5 * DEG);
        push_pair(-(1 << 27), 7, -(1 << 27), -7);
        push_pair(120 * DEG, 0, 120 * DEG, 20 * DEG);
        push_pair(0, 0, 0, (1 << 28) - 1);
        // a pause mid-phase with nothing in flight
        push_fence(1'b0, '0);

        for (int ph = 0; ph < 6; ph++) begin
            if (ph > 0) push_fence(1'b1, radii[ph]);
            for (int i = 0; i < per_phase; i++) push_random_pair();
        end
        // back to the reset radius for a final stretch
        push_fence(1'b1, RADIUS_RESET);
        for (int i = 0; i < 40; i++) push_random_pair();

        aresetn = 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_q.size() != 0 || s_valid || distance_q.size() != 0) @(posedge aclk);
        repeat (LATENCY + 20) @(posedge aclk);
        $display("tb: %0d transactions checked across %0d radius settings", n_checked, n_radius);
        $display("tb: %0d results hit the saturation ceiling", n_saturated);
        if (n_errors == 0 && distance_q.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // ---------------------------------------------------------------------------------------
    // driver: feeds points, holds off at fences, writes the radius while idle
    // ---------------------------------------------------------------------------------------

    int gap_left = 0;
    int settle_cnt = 0;

    always @(posedge aclk) begin
        bit       fire;
        bit       nxt_valid;
        bit       wen;
        bit       quiet;
        pending_t head;
        if (!aresetn) begin
            s_valid <= 1'b0;
            cfg_wen <= 1'b0;
        end else begin
            fire = s_valid && s_ready;
            wen = 1'b0;
            quiet = n_sent >= n_total - QUIET_TAIL;
            if (fire) begin
                head.lat_a = s_lat_a;
                head.lon_a = s_lon_a;
                head.lat_b = s_lat_b;
                head.lon_b = s_lon_b;
                distance_q.insert(distance_q.size(), predict_distance(head, radius_now));
                n_sent++;
            end
            nxt_valid = s_valid && !fire;
            if (!nxt_valid) begin
                if (gap_left > 0 && !quiet) begin
                    gap_left--;
                end else if (pending_q.size() > 0) begin
                    head = pending_q[0];
                    if (head.fence) begin
                        // wait out the whole pipe before touching the radius
                        if (distance_q.size() == 0 && !fire) settle_cnt++;
                        else settle_cnt = 0;
                        if (settle_cnt >= SETTLE) begin
                            settle_cnt = 0;
                            void'(pending_q.pop_front());
                            if (head.wr_radius) begin
                                wen = 1'b1;
                                cfg_wdata <= head.radius;
                                radius_now = head.radius;
                                n_radius++;
                            end
                        end
                    end else begin
                        void'(pending_q.pop_front());
                        nxt_valid = 1'b1;
                        s_lat_a <= head.lat_a;
                        s_lon_a <= head.lon_a;
                        s_lat_b <= head.lat_b;
                        s_lon_b <= head.lon_b;
                        if (!quiet && $urandom_range(0, 7) == 0) gap_left = $urandom_range(1, 7);
                    end
                end
            end
            s_valid <= nxt_valid;
            cfg_wen <= wen;
        end
    end

    // ---------------------------------------------------------------------------------------
    // monitor: random back-pressure, compares each result against the oldest prediction
    // ---------------------------------------------------------------------------------------

    int stall_left = 0;

    always @(posedge aclk) begin
        logic [25:0] want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (distance_q.size() == 0) begin
                    $display("%0t unexpected transaction: expected none actual %0d",
                             $time, m_distance_m);
                    n_errors++;
                end else begin
                    want = distance_q.pop_front();
                    n_checked++;
                    if (want == DIST_MAX) n_saturated++;
                    if (m_distance_m !== want) begin
                        $display("%0t distance_m mismatch: expected %0d actual %0d",
                                 $time, want, m_distance_m);
                        n_errors++;
                    end
                end
            end
            if (stall_left > 0 && n_sent < n_total - QUIET_TAIL) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (n_sent < n_total - QUIET_TAIL && $urandom_range(0, 9) == 0) begin
                stall_left = $urandom_range(0, 6);
                m_ready <= 1'b0;
            end else begin
                stall_left = 0;
                m_ready <= 1'b1;
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

endmodule

// File: files.f
+incdir+src
src/edc_pkg.sv
src/equirectangular_distance_core.sv
dv/equirectangular_distance_core_tb.sv
